// ----- rtl/least_loaded_list_scheduler_core_assert.svh -----
// assertion macros for the least-loaded list scheduler checker
// no dependencies; included by the checker file
`ifndef LEAST_LOADED_LIST_SCHEDULER_CORE_ASSERT_SVH
`define LEAST_LOADED_LIST_SCHEDULER_CORE_ASSERT_SVH

// same-cycle implication
`define LLS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("scheduler assertion failed");

// next-cycle implication
`define LLS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("scheduler assertion failed");

`endif

// ----- rtl/lls_pkg.sv -----
// shared types and constants of the least-loaded list scheduler
// no dependencies
package lls_pkg;

	localparam int MaxProcs  = 16;
	localparam int LoadWidth = 32;

	localparam logic [4:0]  NumProcsReset = 5'd1;
	localparam logic [12:0] NumJobsReset  = 13'd4096;

	// register indexes (paddr bit 2)
	localparam logic RegNumProcs = 1'b0;
	localparam logic RegNumJobs  = 1'b1;

	typedef struct packed {
		logic [11:0] job_id;
		logic [15:0] proc_time;
		logic        restart;
	} job_t;

	typedef struct packed {
		logic [3:0]  processor;
		logic [15:0] encoded_job;
		logic [31:0] new_load;
		logic        load_saturated;
	} res_t;

	typedef struct packed {
		logic [4:0]  num_procs;
		logic [12:0] num_jobs;
	} cfg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

endpackage

// ----- rtl/lls_ram.sv -----
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module lls_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/lls_regs.sv -----
// apb configuration registers: num_procs and num_jobs
// depends on lls_pkg
module lls_regs (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	output lls_pkg::cfg_t cfg
);

	logic        wr;
	logic [4:0]  num_procs_q;
	logic [12:0] num_jobs_q;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_procs_q <= lls_pkg::NumProcsReset;
			num_jobs_q  <= lls_pkg::NumJobsReset;
		end else if (wr) begin
			case (paddr[2])
				lls_pkg::RegNumProcs: num_procs_q <= pwdata[4:0];
				lls_pkg::RegNumJobs:  num_jobs_q  <= pwdata[12:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			lls_pkg::RegNumProcs: prdata = 32'(num_procs_q);
			lls_pkg::RegNumJobs:  prdata = 32'(num_jobs_q);
			default:              prdata = '0;
		endcase
	end

	assign cfg.num_procs = num_procs_q;
	assign cfg.num_jobs  = num_jobs_q;

endmodule

// ----- rtl/lls_ctrl.sv -----
// scan and update sequencer: reads loads one per cycle, keeps the minimum,
// writes the new load back and holds the result; depends on lls_pkg, lls_ram
module lls_ctrl #(
	parameter int MAX_PROCS  = lls_pkg::MaxProcs,
	parameter int LOAD_WIDTH = lls_pkg::LoadWidth
) (
	input  logic          clk,
	input  logic          arst_n,
	input  lls_pkg::cfg_t cfg,
	input  logic          job_valid,
	output logic          job_stall,
	input  lls_pkg::job_t job,
	output logic          res_valid,
	input  logic          res_stall,
	output lls_pkg::res_t res
);

	localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;

	lls_pkg::state_t state_q, state_d;

	logic [IDX_W-1:0]      rd_addr_q;
	logic [IDX_W-1:0]      last_q;
	lls_pkg::job_t         job_q;
	logic [MAX_PROCS-1:0]  vld_q;
	logic                  cmp_vld_s1;
	logic [IDX_W-1:0]      cmp_idx_s1;
	logic                  rvld_s1;
	logic [LOAD_WIDTH-1:0] rdata;
	logic [LOAD_WIDTH-1:0] cur_load;
	logic [LOAD_WIDTH-1:0] best_load_q;
	logic [IDX_W-1:0]      best_idx_q;
	logic                  res_valid_q;
	lls_pkg::res_t         res_q;

	logic                  accept;
	logic                  out_free;
	logic                  rd_en;
	logic                  wr_en;
	logic [IDX_W-1:0]      last_idx;
	logic [LOAD_WIDTH:0]   sum_w;
	logic                  sat;
	logic [LOAD_WIDTH-1:0] load_new;
	logic [63:0]           load_ext;
	logic [IDX_W+12:0]     prod;
	logic [31:0]           enc_w;

	assign out_free = !res_valid_q || !res_stall;
	assign accept   = job_valid && !job_stall;

	// active processor count clamped to 1..MAX_PROCS, kept as last index
	always_comb begin
		if (cfg.num_procs == 5'd0) begin
			last_idx = '0;
		end else if (32'(cfg.num_procs) > 32'(MAX_PROCS)) begin
			last_idx = IDX_W'(MAX_PROCS - 1);
		end else begin
			last_idx = IDX_W'(cfg.num_procs - 5'd1);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lls_pkg::ST_IDLE:  if (job_valid) state_d = lls_pkg::ST_SCAN;
			lls_pkg::ST_SCAN:  if (rd_addr_q == last_q) state_d = lls_pkg::ST_DRAIN;
			lls_pkg::ST_DRAIN: state_d = lls_pkg::ST_DONE;
			lls_pkg::ST_DONE:  if (out_free) state_d = lls_pkg::ST_IDLE;
			default:           state_d = lls_pkg::ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		job_stall = 1'b1;
		rd_en     = 1'b0;
		wr_en     = 1'b0;
		case (state_q)
			lls_pkg::ST_IDLE:  job_stall = 1'b0;
			lls_pkg::ST_SCAN:  rd_en = 1'b1;
			lls_pkg::ST_DRAIN: ;
			lls_pkg::ST_DONE:  wr_en = out_free;
			default:           ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lls_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	lls_ram #(
		.WIDTH(LOAD_WIDTH),
		.DEPTH(MAX_PROCS)
	) u_load_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(best_idx_q),
		.wdata(load_new),
		.re   (rd_en),
		.raddr(rd_addr_q),
		.rdata(rdata)
	);

	// never-written or restarted entries read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (accept && job.restart) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[best_idx_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_vld_s1 <= 1'b0;
		end else begin
			cmp_vld_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			job_q     <= job;
			last_q    <= last_idx;
			rd_addr_q <= '0;
		end else if (rd_en) begin
			rd_addr_q <= rd_addr_q + 1'b1;
		end
		cmp_idx_s1 <= rd_addr_q;
		rvld_s1    <= vld_q[rd_addr_q];
	end

	assign cur_load = rvld_s1 ? rdata : '0;

	// running minimum, strict less keeps the lowest index on ties
	always_ff @(posedge clk) begin
		if (cmp_vld_s1 && (cmp_idx_s1 == '0 || cur_load < best_load_q)) begin
			best_load_q <= cur_load;
			best_idx_q  <= cmp_idx_s1;
		end
	end

	assign sum_w    = {1'b0, best_load_q} + (LOAD_WIDTH+1)'(job_q.proc_time);
	assign sat      = sum_w[LOAD_WIDTH];
	assign load_new = sat ? '1 : sum_w[LOAD_WIDTH-1:0];
	assign load_ext = 64'(load_new);
	assign prod     = (IDX_W+13)'(best_idx_q) * (IDX_W+13)'(cfg.num_jobs);
	assign enc_w    = 32'(job_q.job_id) + 32'(prod);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (wr_en) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			res_q.processor      <= 4'(best_idx_q);
			res_q.encoded_job    <= enc_w[15:0];
			res_q.new_load       <= load_ext[31:0];
			res_q.load_saturated <= sat;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ----- rtl/least_loaded_list_scheduler_core.sv -----
// channel   | handshake                   | payload
// job       | job_valid / job_stall       | lls_pkg::job_t (job_id, proc_time, restart)
// res       | res_valid / res_stall       | lls_pkg::res_t (processor, encoded_job, ...)
// apb cfg   | psel, penable, pwrite       | paddr, pwdata, prdata, pready
//
// from transfer to the next possible transfer a job passes through a scan of the n active
// processors (1..MAX_PROCS), one read of the load ram per cycle, a drain state for the
// last compare, a write-back state and the idle state.
// reset clears config to num_procs=1, num_jobs=4096 and marks all loads zero.
// a stalled result holds the write-back cycle until the output register frees.
// depends on lls_pkg, lls_regs, lls_ctrl, lls_ram
module least_loaded_list_scheduler_core #(
	parameter int MAX_PROCS  = lls_pkg::MaxProcs,
	parameter int LOAD_WIDTH = lls_pkg::LoadWidth
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	input  logic          job_valid,
	output logic          job_stall,
	input  lls_pkg::job_t job,
	output logic          res_valid,
	input  logic          res_stall,
	output lls_pkg::res_t res
);

	lls_pkg::cfg_t cfg;

	lls_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	lls_ctrl #(
		.MAX_PROCS (MAX_PROCS),
		.LOAD_WIDTH(LOAD_WIDTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.job_valid(job_valid),
		.job_stall(job_stall),
		.job      (job),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res)
	);

endmodule

// ----- rtl/lls_checker.sv -----
// port-level checker for the least-loaded list scheduler, bound to the top
// depends on lls_pkg and least_loaded_list_scheduler_core_assert.svh
`include "least_loaded_list_scheduler_core_assert.svh"

module lls_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          job_valid,
	input logic          job_stall,
	input lls_pkg::job_t job,
	input logic          res_valid,
	input logic          res_stall,
	input lls_pkg::res_t res
);

	// one job at a time: busy right after a job transfer
	`LLS_ASSERT_NEXT(a_busy_after_job, clk, arst_n, job_valid && !job_stall, job_stall)

	// a new result only appears while a job is in flight
	`LLS_ASSERT_IMPL(a_res_from_job, clk, arst_n, $rose(res_valid), $past(job_stall))

	// clamped load shows all ones in the low bits
	`LLS_ASSERT_IMPL(a_sat_value, clk, arst_n, res_valid && res.load_saturated, res.new_load[15:0] == 16'hffff)

	// stalled result holds
	`LLS_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && res_stall, res_valid && $stable(res))

endmodule

bind least_loaded_list_scheduler_core lls_checker u_lls_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.job_valid(job_valid),
	.job_stall(job_stall),
	.job      (job),
	.res_valid(res_valid),
	.res_stall(res_stall),
	.res      (res)
);

// ----- tb/least_loaded_list_scheduler_core_test.sv -----
// self-checking bench for the least-loaded list scheduler core: jobs go in over valid/stall,
// register writes over apb, and every assignment is predicted and compared field by field
// depends on lls_pkg and least_loaded_list_scheduler_core
module least_loaded_list_scheduler_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import lls_pkg::*;

	localparam int unsigned CycleLimit   = 2000000;
	localparam int unsigned SettleCycles = 8;
	localparam int unsigned LongHold     = 500;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        psel      = 1'b0;
	logic        penable   = 1'b0;
	logic        pwrite    = 1'b0;
	logic [2:0]  paddr     = '0;
	logic [31:0] pwdata    = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        job_valid = 1'b0;
	logic        job_stall;
	job_t        job       = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	res_t        res;

	// scheduler state as the bench sees it
	logic [LoadWidth-1:0] load_model [MaxProcs];
	logic [4:0]           cfg_num_procs;
	logic [12:0]          cfg_num_jobs;

	job_t        jobs_to_send[$];
	res_t        assignments_due[$];
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned fail_count    = 0;
	int unsigned cycle_count   = 0;
	bit          hold_armed    = 1'b0;
	bit          hold_done     = 1'b0;
	int unsigned hold_left     = 0;

	least_loaded_list_scheduler_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.job_valid (job_valid),
		.job_stall (job_stall),
		.job       (job),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	initial forever #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CycleLimit) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// graham list scheduling: least load among the active processors, lowest index on ties
	function automatic res_t schedule_job(job_t j);
		int unsigned         active;
		int unsigned         best;
		logic [LoadWidth:0]  sum;
		logic [31:0]         code;
		res_t                r;
		active = (cfg_num_procs == 0) ? 1 :
			(cfg_num_procs > MaxProcs) ? MaxProcs : cfg_num_procs;
		if (j.restart) begin
			for (int i = 0; i < MaxProcs; i++)
				load_model[i] = '0;
		end
		best = 0;
		for (int i = 1; i < active; i++) begin
			if (load_model[i] < load_model[best])
				best = i;
		end
		sum = {1'b0, load_model[best]} + j.proc_time;
		r.load_saturated = sum[LoadWidth];
		if (sum[LoadWidth])
			sum = {1'b0, {LoadWidth{1'b1}}};
		load_model[best] = sum[LoadWidth-1:0];
		code = 32'(j.job_id) + best * cfg_num_jobs;
		r.processor   = 4'(best);
		r.encoded_job = code[15:0];
		r.new_load    = sum[31:0];
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	// job sender: a new job may go out once the current one has transferred
	always @(posedge clk) begin
		if (!arst_n) begin
			job_valid <= 1'b0;
		end else begin
			if (job_valid && !job_stall)
				assignments_due.push_back(schedule_job(job));
			if (!job_valid || !job_stall) begin
				if (jobs_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					job       <= jobs_to_send.pop_front();
					job_valid <= 1'b1;
				end else begin
					job_valid <= 1'b0;
				end
			end
		end
	end

	// result receiver and checker
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && !res_stall) begin : check_res
				res_t want;
				if (assignments_due.size() == 0) begin
					$error("result with no job outstanding: processor %0d job %0d",
						res.processor, res.encoded_job);
					fail_count++;
				end else begin
					want = assignments_due.pop_front();
					check_field("processor", 32'(want.processor), 32'(res.processor));
					check_field("encoded_job", 32'(want.encoded_job), 32'(res.encoded_job));
					check_field("new_load", want.new_load, res.new_load);
					check_field("load_saturated", 32'(want.load_saturated),
						32'(res.load_saturated));
				end
			end
			if (hold_armed && !hold_done) begin
				hold_left = LongHold;
				hold_done = 1'b1;
			end
			if (hold_left != 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else begin
				res_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	task automatic push_job(logic [11:0] id, logic [15:0] t, logic rst);
		job_t j;
		j.job_id    = id;
		j.proc_time = t;
		j.restart   = rst;
		jobs_to_send.push_back(j);
	endtask

	// every job transferred and answered, then a settling wait
	task automatic wait_idle();
		do @(negedge clk);
		while (jobs_to_send.size() != 0 || job_valid || assignments_due.size() != 0);
		repeat (SettleCycles) @(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == RegNumProcs)
			cfg_num_procs = value[4:0];
		else
			cfg_num_jobs = value[12:0];
		@(negedge clk);
	endtask

	task automatic random_jobs(int unsigned chunks, int unsigned per_chunk);
		logic [15:0] t;
		for (int c = 0; c < chunks; c++) begin
			wait_idle();
			write_reg(RegNumProcs, $urandom_range(31));
			write_reg(RegNumJobs, $urandom_range(8191));
			for (int k = 0; k < per_chunk; k++) begin
				case ($urandom_range(9))
					0: t = 16'h0000;
					1: t = 16'hFFFF;
					2, 3, 4: t = 16'($urandom_range(15));
					default: t = 16'($urandom_range(65535));
				endcase
				push_job(12'($urandom_range(4095)), t, $urandom_range(49) == 0);
			end
		end
	endtask

	initial begin
		cfg_num_procs = NumProcsReset;
		cfg_num_jobs  = NumJobsReset;
		for (int i = 0; i < MaxProcs; i++)
			load_model[i] = '0;
		send_idle_pct = 6;
		recv_idle_pct = 71;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// settings straight out of reset
		push_job(12'd0, 16'd0, 1'b0);
		push_job(12'd4095, 16'hFFFF, 1'b0);
		wait_idle();

		// all sixteen tied at zero: job k lands on processor k, the last code is 65535
		write_reg(RegNumProcs, 32'd16);
		write_reg(RegNumJobs, 32'd4096);
		for (int k = 0; k < 16; k++)
			push_job((k == 15) ? 12'd4095 : 12'(k * 7), 16'd10, k == 0);
		wait_idle();

		// zero processors acts as one, zero job count leaves the id alone
		write_reg(RegNumProcs, 32'd0);
		write_reg(RegNumJobs, 32'd0);
		push_job(12'd4095, 16'd1, 1'b0);
		push_job(12'd5, 16'd2, 1'b0);
		wait_idle();

		// too many processors clamps to sixteen
		write_reg(RegNumProcs, 32'd31);
		write_reg(RegNumJobs, 32'd8191);
		push_job(12'd4095, 16'hFFFF, 1'b0);
		push_job(12'd1, 16'd0, 1'b1);

		random_jobs(5, 100);

		send_idle_pct = 71;
		recv_idle_pct = 6;
		random_jobs(5, 100);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		wait_idle();
		hold_armed = 1'b1;
		random_jobs(5, 100);

		// only two processors compete, the inactive loads stay until the restart
		wait_idle();
		write_reg(RegNumProcs, 32'd2);
		write_reg(RegNumJobs, 32'd1);
		push_job(12'd4, 16'd100, 1'b0);
		push_job(12'd5, 16'd100, 1'b1);

		wait_idle();
		repeat (20) @(negedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
